// ===== hdl/swdg_pkg.sv =====
package swdg_pkg;

    // Item functions
    typedef enum logic [1:0] {
        FUNC_CYCLES  = 2'd0,
        FUNC_SWEEP   = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_STOP    = 2'd3
    } func_t;

    // Register map, index = paddr / 4
    typedef enum logic [2:0] {
        REG_DUTY_SELECT     = 3'd0,
        REG_START_FREQUENCY = 3'd1,
        REG_SWEEP_PERIOD    = 3'd2,
        REG_SWEEP_DECREASE  = 3'd3,
        REG_SWEEP_SHIFT     = 3'd4,
        REG_SWEEP_ENABLE    = 3'd5,
        REG_UNUSED_6        = 3'd6,
        REG_UNUSED_7        = 3'd7
    } reg_index_t;

    localparam int FREQ_W   = 11;
    localparam int COUNT_W  = 14;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    localparam logic [COUNT_W-1:0] PERIOD_RESET = 14'd8192;
    localparam logic [COUNT_W-1:0] ACC_MAX      = 14'd16383;

    // Duty patterns, bit n is step n
    localparam logic [7:0] DUTY_PATTERN [4] = '{
        8'b1000_0000,
        8'b1000_0001,
        8'b1110_0001,
        8'b0111_1110
    };

    typedef struct packed {
        func_t      func;
        logic [7:0] cycles;
    } item_t;

    typedef struct packed {
        logic              level;
        logic              running;
        logic [FREQ_W-1:0] frequency;
        logic [2:0]        duty_position;
    } result_t;

    // Step period in clocks: (2048 - f) * 4
    function automatic logic [COUNT_W-1:0] period_of(input logic [FREQ_W-1:0] f);
        logic [FREQ_W:0] d;
        d = 12'h800 - {1'b0, f};
        return {d, 2'b00};
    endfunction

    function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] pat;
        pat = DUTY_PATTERN[sel];
        return pat[pos];
    endfunction

endpackage

// ===== hdl/square_wave_duty_generator_with_sweep.sv =====
// Square wave channel with 8-step duty pattern and frequency sweep. Each beat on
// the item channel is one of: elapsed clocks, sweep tick, restart or stop, and
// yields exactly one result beat carrying the latched level, the running flag,
// the current frequency code and the duty position after that item. The block
// takes one item per clock while the result channel is not stalled. An accepted
// item is held in the input register, and one pass of the state update then loads
// the result register once it is free or drained. The state update is combinational
// around the channel state, so back-to-back items see each other's effect. Registers
// are written through the APB port at byte address 4*index; a sweep update writes the
// new frequency back into the start frequency register.
module square_wave_duty_generator_with_sweep
    import swdg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // item channel
    input  logic               item_valid,
    output logic               item_ready,
    input  item_t              item,
    // result channel
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result
);

    // Configuration registers
    logic [1:0]        duty_select_reg;
    logic [FREQ_W-1:0] start_freq_reg;
    logic [2:0]        sweep_period_reg;
    logic              sweep_decrease_reg;
    logic [2:0]        sweep_shift_reg;
    logic              sweep_enable_reg;

    // Channel state
    logic [FREQ_W-1:0]  freq_reg,   freq_next;
    logic [COUNT_W-1:0] period_reg, period_next;
    logic [COUNT_W-1:0] acc_reg,    acc_next;
    logic [2:0]         step_reg,   step_next;
    logic [2:0]         timer_reg,  timer_next;
    logic               chan_on_reg, chan_on_next;
    logic               level_reg,  level_next;
    logic [1:0]         lat_duty_reg,     lat_duty_next;
    logic [2:0]         lat_period_reg,   lat_period_next;
    logic               lat_decrease_reg, lat_decrease_next;
    logic [2:0]         lat_shift_reg,    lat_shift_next;

    // Pipeline
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    result_valid_reg;
    result_t result_reg;
    logic    advance;

    // Datapath intermediates
    logic [COUNT_W:0]   acc_sum;
    logic [COUNT_W-1:0] acc_sat;
    logic [2:0]         step_inc;
    logic [2:0]         timer_inc;
    logic [FREQ_W-1:0]  delta;
    logic [FREQ_W:0]    freq_sum;
    logic [FREQ_W-1:0]  freq_diff;
    logic               sweep_update;

    logic       cfg_write;
    reg_index_t cfg_index;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[PADDR_W-1:2]);
    assign pready    = 1'b1;

    // Register writes; a sweep update writes the frequency back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_select_reg    <= '0;
            start_freq_reg     <= '0;
            sweep_period_reg   <= '0;
            sweep_decrease_reg <= 1'b0;
            sweep_shift_reg    <= '0;
            sweep_enable_reg   <= 1'b0;
        end
        else
        begin
            if (sweep_update)
            begin
                start_freq_reg <= freq_next;
            end
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_DUTY_SELECT:     duty_select_reg    <= pwdata[1:0];
                    REG_START_FREQUENCY: start_freq_reg     <= pwdata[FREQ_W-1:0];
                    REG_SWEEP_PERIOD:    sweep_period_reg   <= pwdata[2:0];
                    REG_SWEEP_DECREASE:  sweep_decrease_reg <= pwdata[0];
                    REG_SWEEP_SHIFT:     sweep_shift_reg    <= pwdata[2:0];
                    REG_SWEEP_ENABLE:    sweep_enable_reg   <= pwdata[0];
                    default:             ;
                endcase
            end
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            REG_DUTY_SELECT:     prdata = {30'd0, duty_select_reg};
            REG_START_FREQUENCY: prdata = {21'd0, start_freq_reg};
            REG_SWEEP_PERIOD:    prdata = {29'd0, sweep_period_reg};
            REG_SWEEP_DECREASE:  prdata = {31'd0, sweep_decrease_reg};
            REG_SWEEP_SHIFT:     prdata = {29'd0, sweep_shift_reg};
            REG_SWEEP_ENABLE:    prdata = {31'd0, sweep_enable_reg};
            default:             prdata = '0;
        endcase
    end

    // Handshake: stage 1 moves on when the result register is free or drained
    assign advance      = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready   = !s1_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Hold the accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            s1_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_item_reg <= item;
        end
    end

    // Shared arithmetic
    assign acc_sum   = {1'b0, acc_reg} + {{(COUNT_W-7){1'b0}}, s1_item_reg.cycles};
    assign acc_sat   = acc_sum[COUNT_W] ? ACC_MAX : acc_sum[COUNT_W-1:0];
    assign step_inc  = step_reg + 3'd1;
    assign timer_inc = (timer_reg != lat_period_reg) ? timer_reg + 3'd1 : timer_reg;
    assign delta     = freq_reg >> lat_shift_reg;
    assign freq_sum  = {1'b0, freq_reg} + {1'b0, delta};
    assign freq_diff = freq_reg - delta;

    // Next channel state for the item in stage 1
    always_comb
    begin
        freq_next         = freq_reg;
        period_next       = period_reg;
        acc_next          = acc_reg;
        step_next         = step_reg;
        timer_next        = timer_reg;
        chan_on_next      = chan_on_reg;
        level_next        = level_reg;
        lat_duty_next     = lat_duty_reg;
        lat_period_next   = lat_period_reg;
        lat_decrease_next = lat_decrease_reg;
        lat_shift_next    = lat_shift_reg;
        sweep_update      = 1'b0;
        if (advance)
        begin
            unique case (s1_item_reg.func)
                FUNC_CYCLES:
                begin
                    acc_next = acc_sat;
                    if (acc_sat >= period_reg)
                    begin
                        step_next  = step_inc;
                        level_next = chan_on_reg && duty_bit(lat_duty_reg, step_inc);
                        acc_next   = acc_sat - period_reg;
                    end
                end
                FUNC_SWEEP:
                begin
                    if (sweep_enable_reg && (lat_period_reg != 3'd0))
                    begin
                        timer_next = timer_inc;
                        if (timer_inc == lat_period_reg)
                        begin
                            // drop the update on underflow or stop on overflow
                            priority if (lat_decrease_reg && (delta > freq_reg))
                            begin
                                timer_next = 3'd0;
                            end
                            else if (!lat_decrease_reg && freq_sum[FREQ_W])
                            begin
                                chan_on_next = 1'b0;
                            end
                            else
                            begin
                                freq_next    = lat_decrease_reg ? freq_diff
                                                                : freq_sum[FREQ_W-1:0];
                                period_next  = period_of(freq_next);
                                acc_next     = '0;
                                timer_next   = 3'd0;
                                sweep_update = 1'b1;
                            end
                        end
                    end
                end
                FUNC_RESTART:
                begin
                    chan_on_next      = 1'b1;
                    lat_duty_next     = duty_select_reg;
                    freq_next         = start_freq_reg;
                    period_next       = period_of(start_freq_reg);
                    acc_next          = '0;
                    step_next         = 3'd0;
                    timer_next        = 3'd0;
                    lat_period_next   = sweep_period_reg;
                    lat_decrease_next = sweep_decrease_reg;
                    lat_shift_next    = sweep_shift_reg;
                end
                FUNC_STOP:
                begin
                    chan_on_next = 1'b0;
                end
                default:
                begin
                    chan_on_next = chan_on_reg;
                end
            endcase
        end
    end

    // Channel state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            freq_reg         <= '0;
            period_reg       <= PERIOD_RESET;
            acc_reg          <= '0;
            step_reg         <= '0;
            timer_reg        <= '0;
            chan_on_reg      <= 1'b0;
            level_reg        <= 1'b0;
            lat_duty_reg     <= '0;
            lat_period_reg   <= '0;
            lat_decrease_reg <= 1'b0;
            lat_shift_reg    <= '0;
        end
        else
        begin
            freq_reg         <= freq_next;
            period_reg       <= period_next;
            acc_reg          <= acc_next;
            step_reg         <= step_next;
            timer_reg        <= timer_next;
            chan_on_reg      <= chan_on_next;
            level_reg        <= level_next;
            lat_duty_reg     <= lat_duty_next;
            lat_period_reg   <= lat_period_next;
            lat_decrease_reg <= lat_decrease_next;
            lat_shift_reg    <= lat_shift_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg.level         <= level_next;
            result_reg.running       <= chan_on_next;
            result_reg.frequency     <= freq_next;
            result_reg.duty_position <= step_next;
        end
    end

    // Checks
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && result_valid_reg && !result_ready) |-> !item_ready)
        else $error("item taken while stage 1 is stalled");

    a_period_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (period_reg != '0) && (period_reg[1:0] == 2'b00))
        else $error("step period not a non-zero multiple of four");

    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_item_reg.func == FUNC_STOP)) |=> !chan_on_reg && !result.running)
        else $error("stop did not clear running");

    a_restart_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_item_reg.func == FUNC_RESTART))
            |=> chan_on_reg && (step_reg == 3'd0) && (acc_reg == '0) && (timer_reg == 3'd0))
        else $error("restart did not reload the channel");

endmodule

// ===== sim/tb_square_wave_duty_generator_with_sweep.sv =====
`timescale 1ns / 1ps

module tb_square_wave_duty_generator_with_sweep;
    import swdg_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               item_valid = 1'b0;
    logic               item_ready;
    item_t              item = '0;
    logic               result_valid;
    logic               result_ready = 1'b0;
    result_t            result;

    square_wave_duty_generator_with_sweep uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #5 clk = ~clk;

    // Register copies as the block should hold them
    logic [1:0]        cfg_duty = '0;
    logic [FREQ_W-1:0] cfg_start_freq = '0;
    logic [2:0]        cfg_sweep_period = '0;
    logic              cfg_decrease = 1'b0;
    logic [2:0]        cfg_shift = '0;
    logic              cfg_sweep_en = 1'b0;

    // Channel state as the block should hold it
    logic [FREQ_W-1:0]  freq_now = '0;
    logic [COUNT_W-1:0] period_now = 14'd8192;
    logic [COUNT_W-1:0] acc_now = '0;
    logic [2:0]         step_now = '0;
    logic [2:0]         sweep_count = '0;
    logic               on_now = 1'b0;
    logic               level_now = 1'b0;
    logic [1:0]         lat_duty = '0;
    logic [2:0]         lat_sweep_period = '0;
    logic               lat_decrease = 1'b0;
    logic [2:0]         lat_shift = '0;

    item_t   item_backlog[$];
    result_t predicted_status[$];
    result_t want;
    int      mismatch_count = 0;
    int      send_gap = 0;
    int      stall_left = 0;
    logic    no_gaps = 1'b0;
    logic    holding;

    function automatic logic [COUNT_W-1:0] step_period_for(input logic [FREQ_W-1:0] f);
        return COUNT_W'((2048 - int'(f)) * 4);
    endfunction

    // Mostly short gaps, a few long ones, none in quiet phases
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // Advance the channel by one item and return the status it should report
    function automatic result_t advance_channel(input item_t it);
        result_t     st;
        int          sum;
        logic [0:7]  shape;
        logic [FREQ_W-1:0] delta;
        case (it.func)
            FUNC_CYCLES:
            begin
                sum = int'(acc_now) + int'(it.cycles);
                if (sum > 16383)
                    sum = 16383;
                acc_now = COUNT_W'(sum);
                if (acc_now >= period_now)
                begin
                    step_now = step_now + 3'd1;
                    case (lat_duty)
                        2'd0:    shape = 8'b0000_0001;
                        2'd1:    shape = 8'b1000_0001;
                        2'd2:    shape = 8'b1000_0111;
                        default: shape = 8'b0111_1110;
                    endcase
                    level_now = on_now ? shape[step_now] : 1'b0;
                    acc_now = acc_now - period_now;
                end
            end
            FUNC_SWEEP:
            begin
                if (cfg_sweep_en && lat_sweep_period != 3'd0)
                begin
                    if (sweep_count != lat_sweep_period)
                        sweep_count = sweep_count + 3'd1;
                    if (sweep_count == lat_sweep_period)
                    begin
                        delta = freq_now >> lat_shift;
                        if (lat_decrease && delta > freq_now)
                            sweep_count = '0;
                        else if (!lat_decrease && ({1'b0, freq_now} + {1'b0, delta}) > 12'd2047)
                            on_now = 1'b0;
                        else
                        begin
                            freq_now = lat_decrease ? freq_now - delta : freq_now + delta;
                            period_now = step_period_for(freq_now);
                            acc_now = '0;
                            sweep_count = '0;
                            cfg_start_freq = freq_now;
                        end
                    end
                end
            end
            FUNC_RESTART:
            begin
                on_now = 1'b1;
                lat_duty = cfg_duty;
                freq_now = cfg_start_freq;
                period_now = step_period_for(freq_now);
                acc_now = '0;
                step_now = '0;
                sweep_count = '0;
                lat_sweep_period = cfg_sweep_period;
                lat_decrease = cfg_decrease;
                lat_shift = cfg_shift;
            end
            default:
            begin
                on_now = 1'b0;
            end
        endcase
        st.level = level_now;
        st.running = on_now;
        st.frequency = freq_now;
        st.duty_position = step_now;
        return st;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        if (mismatch_count < 200)
            $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, exp_val);
        mismatch_count++;
    endtask

    // Item driver: hold each beat until taken, then leave a random gap
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            holding = item_valid;
            if (item_valid && item_ready)
            begin
                predicted_status.push_back(advance_channel(item));
                holding = 1'b0;
            end
            if (!holding)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (item_backlog.size() != 0)
                begin
                    item <= item_backlog.pop_front();
                    item_valid <= 1'b1;
                    send_gap = idle_len();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each beat against the oldest prediction, stall at random
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (predicted_status.size() == 0)
                begin
                    flag_mismatch("unexpected result", 32'(result), 32'd0);
                end
                else
                begin
                    want = predicted_status.pop_front();
                    if (result.level !== want.level)
                        flag_mismatch("level", 32'(result.level), 32'(want.level));
                    if (result.running !== want.running)
                        flag_mismatch("running", 32'(result.running), 32'(want.running));
                    if (result.frequency !== want.frequency)
                        flag_mismatch("frequency", 32'(result.frequency), 32'(want.frequency));
                    if (result.duty_position !== want.duty_position)
                        flag_mismatch("duty_position", 32'(result.duty_position),
                                      32'(want.duty_position));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_DUTY_SELECT:     cfg_duty = val[1:0];
            REG_START_FREQUENCY: cfg_start_freq = val[FREQ_W-1:0];
            REG_SWEEP_PERIOD:    cfg_sweep_period = val[2:0];
            REG_SWEEP_DECREASE:  cfg_decrease = val[0];
            REG_SWEEP_SHIFT:     cfg_shift = val[2:0];
            REG_SWEEP_ENABLE:    cfg_sweep_en = val[0];
            default:             ;
        endcase
    endtask

    task automatic apply_config(input int duty, input int start_f, input int sweep_per,
                                input int decrease, input int shift, input int sweep_en);
        write_reg(REG_DUTY_SELECT, PDATA_W'(duty));
        write_reg(REG_START_FREQUENCY, PDATA_W'(start_f));
        write_reg(REG_SWEEP_PERIOD, PDATA_W'(sweep_per));
        write_reg(REG_SWEEP_DECREASE, PDATA_W'(decrease));
        write_reg(REG_SWEEP_SHIFT, PDATA_W'(shift));
        write_reg(REG_SWEEP_ENABLE, PDATA_W'(sweep_en));
    endtask

    task automatic push_item(input func_t f, input int c);
        item_t it;
        it.func = f;
        it.cycles = 8'(c);
        item_backlog.push_back(it);
    endtask

    // Wait until every beat is sent and every result is back
    task automatic wait_idle();
        while (item_backlog.size() != 0 || item_valid || predicted_status.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int   sent;
        int   n;
        int   r;
        int   start_f;
        logic heavy;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Channel never started: clocks accumulate with the level held low
        push_item(FUNC_CYCLES, 255);
        push_item(FUNC_CYCLES, 0);
        push_item(FUNC_SWEEP, 0);
        push_item(FUNC_STOP, 0);
        wait_idle();

        // Top frequency, shortest period, sweep overflow stops the channel
        apply_config(3, 2047, 1, 0, 0, 1);
        push_item(FUNC_RESTART, 0);
        push_item(FUNC_CYCLES, 4);
        push_item(FUNC_CYCLES, 3);
        push_item(FUNC_CYCLES, 1);
        push_item(FUNC_CYCLES, 255);
        push_item(FUNC_SWEEP, 0);
        push_item(FUNC_CYCLES, 4);
        push_item(FUNC_RESTART, 0);
        push_item(FUNC_STOP, 0);
        push_item(FUNC_CYCLES, 8);
        push_item(FUNC_RESTART, 0);
        wait_idle();

        // Longest sweep period with a decreasing sweep
        apply_config(2, 1024, 7, 1, 1, 1);
        push_item(FUNC_RESTART, 0);
        repeat (7) push_item(FUNC_SWEEP, 0);
        push_item(FUNC_CYCLES, 255);
        wait_idle();
        sent = 24;

        // Random phases: fresh settings, then a restart followed by random traffic
        while (sent < 1650)
        begin
            no_gaps <= ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 3);
            if (r == 0)
                start_f = $urandom_range(0, 1) ? 2047 : 0;
            else if (r == 1)
                start_f = $urandom_range(0, 2047);
            else
                start_f = $urandom_range(1900, 2047);
            apply_config($urandom_range(0, 3), start_f, $urandom_range(0, 7),
                         $urandom_range(0, 1), $urandom_range(0, 7),
                         ($urandom_range(0, 4) != 0));
            // Large counts push the accumulator into saturation at short periods
            heavy = ($urandom_range(0, 3) == 0);
            n = $urandom_range(20, 80);
            if ($urandom_range(0, 9) != 0)
                push_item(FUNC_RESTART, $urandom_range(0, 255));
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    push_item(FUNC_CYCLES, heavy ? $urandom_range(200, 255)
                                                 : $urandom_range(0, 255));
                else if (r < 88)
                    push_item(FUNC_SWEEP, $urandom_range(0, 255));
                else if (r < 95)
                    push_item(FUNC_RESTART, $urandom_range(0, 255));
                else
                    push_item(FUNC_STOP, $urandom_range(0, 255));
            end
            sent += n + 1;
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
